FILE: hdl/pit_pkg.sv
// Package for the programmable interval timer.
// Holds command codes, control bit positions, reset values and the state type.
// No dependencies.
package pit_pkg;

	localparam int unsigned WordW = 16;
	localparam int unsigned PreW  = 7;

	typedef logic [WordW-1:0] word_t;
	typedef logic [PreW-1:0]  pre_t;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_RELOAD  = 2'd1,
		CMD_CONTROL = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PRE_DIV1  = 2'd0,
		PRE_DIV16 = 2'd1,
		PRE_DIV4  = 2'd2,
		PRE_DIV64 = 2'd3
	} pre_sel_t;

	localparam int unsigned CtlStop      = 0;
	localparam int unsigned CtlWrap      = 1;
	localparam int unsigned CtlExpEnable = 2;
	localparam int unsigned CtlOneShot   = 3;
	localparam int unsigned CtlRun       = 4;
	localparam int unsigned CtlPreLo     = 5;
	localparam int unsigned CtlPreHi     = 6;
	localparam int unsigned CtlExpiry    = 7;

	localparam word_t CtlForced   = 16'hFF00;
	localparam word_t CountReset  = 16'hFFFF;
	localparam word_t ReloadReset = 16'h1200;
	localparam word_t CtlReset    = 16'hFF00;

	localparam pre_t Div16 = 7'd16;
	localparam pre_t Div4  = 7'd4;
	localparam pre_t Div64 = 7'd64;

	typedef struct packed {
		word_t count;
		word_t control;
		word_t reload;
	} pit_state_t;

endpackage

FILE: hdl/pit_if.sv
// Channel interfaces of the programmable interval timer.
// pit_req_if carries commands, pit_res_if carries results; both use pit_pkg.
interface pit_req_if import pit_pkg::*; ();
	logic  valid;
	logic  ready;
	cmd_t  cmd;
	word_t data;

	modport source (output valid, output cmd, output data, input ready);
	modport sink   (input valid, input cmd, input data, output ready);
endinterface

interface pit_res_if import pit_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t count;
	word_t control_word;
	word_t reload_value;

	modport source (output valid, output count, output control_word,
		output reload_value, input ready);
	modport sink   (input valid, input count, input control_word,
		input reload_value, output ready);
endinterface

FILE: hdl/programmable_interval_timer.sv
// Programmable interval timer: 16-bit down-counter with prescaler and reload.
// Pipeline: an accepted transaction is held in stage one, then its result is registered for the result channel.
// Throughput: one transaction per cycle while the result channel is not stalled; the state update is a single pass.
// Reset: arst_n clears counter to 0xFFFF, reload to 0x1200, control to 0xFF00.
// Depends on pit_pkg, pit_if and pit_core.
module programmable_interval_timer import pit_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pit_req_if.sink    request,
	pit_res_if.source  result
);

	logic       valid_s1;
	cmd_t       cmd_s1;
	word_t      data_s1;
	logic       advance;
	logic       res_valid_q;
	pit_state_t res_q;
	pit_state_t nxt;

	assign advance       = valid_s1 && (!res_valid_q || result.ready);
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			cmd_s1  <= request.cmd;
			data_s1 <= request.data;
		end
	end

	pit_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cmd     (cmd_s1),
		.data    (data_s1),
		.nxt     (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= nxt;
	end

	assign result.valid        = res_valid_q;
	assign result.count        = res_q.count;
	assign result.control_word = res_q.control;
	assign result.reload_value = res_q.reload;

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance))
		else $error("result appeared without a transaction in stage one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |-> !advance)
		else $error("pending result would be overwritten");

	a_stage_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !request.ready |=> valid_s1 && $stable(cmd_s1) && $stable(data_s1))
		else $error("stalled transaction in stage one was lost");

endmodule

FILE: hdl/pit_core.sv
// Timer state registers and the single-step update logic.
// Depends on pit_pkg.
module pit_core import pit_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  cmd_t       cmd,
	input  word_t      data,
	output pit_state_t nxt
);

	word_t cnt_q;
	word_t rel_q;
	word_t ctl_q;
	pre_t  pre_q;

	word_t nxt_cnt;
	word_t nxt_rel;
	word_t nxt_ctl;
	pre_t  nxt_pre;
	pre_t  pre_inc;
	word_t dec;
	logic  fire;

	assign pre_inc = pre_q + 1'b1;
	assign dec     = cnt_q - 1'b1;

	always_comb begin
		case (pre_sel_t'(ctl_q[CtlPreHi:CtlPreLo]))
			PRE_DIV1:  fire = 1'b1;
			PRE_DIV16: fire = (pre_inc >= Div16);
			PRE_DIV4:  fire = (pre_inc >= Div4);
			PRE_DIV64: fire = (pre_inc >= Div64);
			default:   fire = 1'b1;
		endcase
	end

	always_comb begin
		nxt_cnt = cnt_q;
		nxt_rel = rel_q;
		nxt_ctl = ctl_q;
		nxt_pre = pre_q;
		case (cmd)
			CMD_TICK: begin
				if (ctl_q[CtlStop]) begin
					nxt_cnt = rel_q;
				end else if (ctl_q[CtlRun]) begin
					if (!fire) begin
						nxt_pre = pre_inc;
					end else begin
						nxt_pre = '0;
						nxt_cnt = dec;
						if (dec == '0) begin
							if (!ctl_q[CtlWrap]) begin
								if (ctl_q[CtlOneShot])
									nxt_ctl[CtlRun] = 1'b0;
								nxt_cnt = rel_q;
							end
							if (ctl_q[CtlExpEnable])
								nxt_ctl[CtlExpiry] = 1'b1;
						end
					end
				end
			end
			CMD_RELOAD: begin
				nxt_rel = data;
			end
			CMD_CONTROL: begin
				nxt_cnt = rel_q;
				nxt_ctl = CtlForced | data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CountReset;
			rel_q <= ReloadReset;
			ctl_q <= CtlReset;
			pre_q <= '0;
		end else if (step_en) begin
			cnt_q <= nxt_cnt;
			rel_q <= nxt_rel;
			ctl_q <= nxt_ctl;
			pre_q <= nxt_pre;
		end
	end

	assign nxt.count   = nxt_cnt;
	assign nxt.control = nxt_ctl;
	assign nxt.reload  = nxt_rel;

	a_ctl_upper: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q[15:8] == 8'hFF)
		else $error("control upper byte lost its forced ones");

	a_pre_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pre_q < Div64)
		else $error("prescaler count ran past its largest divisor");

	a_ctl_load: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && cmd == CMD_CONTROL |=> cnt_q == $past(rel_q))
		else $error("control write did not load the counter from reload");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(cnt_q) && $stable(rel_q) && $stable(ctl_q) && $stable(pre_q))
		else $error("timer state changed without a transaction");

endmodule
